// ----- rtl/tmc_pkg.sv -----
// Shared types and constants of the touch coordinate mapper.
// No dependencies; every other file of the block imports this package.
package tmc_pkg;

	localparam int RAW_W      = 12;
	localparam int PROD_W     = 2 * RAW_W;
	localparam int X_W        = 9;
	localparam int Y_W        = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MIN    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MAX    = 3'd7;

	localparam logic [RAW_W-1:0] CAL_MAX_RESET = 12'd4095;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [RAW_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/tmc_stream_if.sv -----
// Valid/ready channels of the touch coordinate mapper: poll input and point output.
// Depends on tmc_pkg for field widths.
interface tmc_in_if;
	import tmc_pkg::*;

	logic             valid;
	logic             ready;
	logic             edge_seen;
	logic             line_low;
	logic             touch_valid;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, output edge_seen, output line_low, output touch_valid,
		output raw_x, output raw_y, input ready);
	modport sink (input valid, input edge_seen, input line_low, input touch_valid,
		input raw_x, input raw_y, output ready);
endinterface

interface tmc_out_if;
	import tmc_pkg::*;

	logic           valid;
	logic           ready;
	logic           touch_pressed;
	logic [X_W-1:0] point_x;
	logic [Y_W-1:0] point_y;

	modport source (output valid, output touch_pressed, output point_x, output point_y,
		input ready);
	modport sink (input valid, input touch_pressed, input point_x, input point_y,
		output ready);
endinterface

// ----- rtl/tmc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tmc_pkg for div_req_t and div_rsp_t.
module tmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tmc_pkg::div_req_t req,
	output tmc_pkg::div_rsp_t rsp
);
	import tmc_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAW_W-1:0]  rem_q;
	logic [RAW_W-1:0]  dsr_q;
	logic [PROD_W-1:0] quo_q;
	logic [RAW_W:0]    shifted;
	logic [RAW_W:0]    diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/touch_coordinate_mapper_top.sv -----
// Touch coordinate mapper top level: poll gating, calibration mapping, mirroring.
// Depends on tmc_pkg, tmc_in_if/tmc_out_if and the shared divider tmc_div.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | edge_seen, line_low, touch_valid, raw_x, raw_y
//   out_ch   | out | valid/ready        | touch_pressed, point_x, point_y
//   cfg      | in  | cfg_we             | cfg_idx, cfg_data
//
// Scaled and pressed: each of the two axes passes through a multiply state, a load
// state and the one shared 24-bit divider.
// Unscaled or released: the transaction goes from idle straight to the output state.
// Reset clears configuration to its defaults and the pressed flag to released.
// in_ch.ready is low while a transaction is in progress; a result waiting on a
// stalled out_ch does not block the next accept, only the next result load.
module touch_coordinate_mapper_top #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tmc_in_if.sink                           in_ch,
	tmc_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [tmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tmc_pkg::*;

	localparam logic [RAW_W-1:0] TOP_X = RAW_W'(SCREEN_WIDTH - 1);
	localparam logic [RAW_W-1:0] TOP_Y = RAW_W'(SCREEN_HEIGHT - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic              axis_q;
	logic [RAW_W-1:0]  a_q;
	logic [RAW_W-1:0]  b_q;
	logic [RAW_W-1:0]  xr_q;
	logic [RAW_W-1:0]  yr_q;
	logic              pressed_q;
	logic              was_pressed_q;
	logic [PROD_W-1:0] prod_q;
	logic [RAW_W-1:0]  den_abs_q;
	logic              zero_q;

	logic              swap_axes_q;
	logic              mirror_x_q;
	logic              mirror_y_q;
	logic              scale_enable_q;
	logic [RAW_W-1:0]  cal_x_min_q;
	logic [RAW_W-1:0]  cal_x_max_q;
	logic [RAW_W-1:0]  cal_y_min_q;
	logic [RAW_W-1:0]  cal_y_max_q;

	logic              out_valid_q;
	logic              out_pressed_q;
	logic [X_W-1:0]    out_x_q;
	logic [Y_W-1:0]    out_y_q;

	logic              accept;
	logic              pressed;
	logic [RAW_W-1:0]  sw_a;
	logic [RAW_W-1:0]  sw_b;
	logic [RAW_W-1:0]  sel_raw;
	logic [RAW_W-1:0]  sel_lo;
	logic [RAW_W-1:0]  sel_hi;
	logic [RAW_W-1:0]  sel_top;
	logic [RAW_W:0]    num;
	logic [RAW_W:0]    den;
	logic [RAW_W-1:0]  num_abs;
	logic [RAW_W-1:0]  den_abs;
	logic [RAW_W-1:0]  clamp_res;
	logic [RAW_W-1:0]  mir_x;
	logic [RAW_W-1:0]  mir_y;
	logic              out_load;

	div_req_t div_req;
	div_rsp_t div_rsp;

	tmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign pressed     = (in_ch.edge_seen || in_ch.line_low || was_pressed_q) &&
		in_ch.touch_valid;
	assign sw_a        = swap_axes_q ? in_ch.raw_y : in_ch.raw_x;
	assign sw_b        = swap_axes_q ? in_ch.raw_x : in_ch.raw_y;

	assign sel_raw = axis_q ? b_q : a_q;
	assign sel_lo  = axis_q ? cal_y_min_q : cal_x_min_q;
	assign sel_hi  = axis_q ? cal_y_max_q : cal_x_max_q;
	assign sel_top = axis_q ? TOP_Y : TOP_X;
	assign num     = {1'b0, sel_raw} - {1'b0, sel_lo};
	assign den     = {1'b0, sel_hi} - {1'b0, sel_lo};
	assign num_abs = num[RAW_W] ? RAW_W'(-num) : num[RAW_W-1:0];
	assign den_abs = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];

	assign clamp_res = zero_q ? '0 :
		(div_rsp.quotient > {{(PROD_W-RAW_W){1'b0}}, sel_top}) ? sel_top :
		div_rsp.quotient[RAW_W-1:0];

	assign div_req.start    = (state_q == S_LOAD);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = den_abs_q;

	assign mir_x    = mirror_x_q ? TOP_X - xr_q : xr_q;
	assign mir_y    = mirror_y_q ? TOP_Y - yr_q : yr_q;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_axes_q    <= 1'b0;
			mirror_x_q     <= 1'b0;
			mirror_y_q     <= 1'b0;
			scale_enable_q <= 1'b0;
			cal_x_min_q    <= '0;
			cal_x_max_q    <= CAL_MAX_RESET;
			cal_y_min_q    <= '0;
			cal_y_max_q    <= CAL_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SWAP_AXES:    swap_axes_q    <= cfg_data[0];
				REG_MIRROR_X:     mirror_x_q     <= cfg_data[0];
				REG_MIRROR_Y:     mirror_y_q     <= cfg_data[0];
				REG_SCALE_ENABLE: scale_enable_q <= cfg_data[0];
				REG_CAL_X_MIN:    cal_x_min_q    <= cfg_data[RAW_W-1:0];
				REG_CAL_X_MAX:    cal_x_max_q    <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MIN:    cal_y_min_q    <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MAX:    cal_y_max_q    <= cfg_data[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			axis_q        <= 1'b0;
			pressed_q     <= 1'b0;
			was_pressed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pressed_q <= pressed;
						axis_q    <= 1'b0;
						if (in_ch.edge_seen || in_ch.line_low || was_pressed_q) begin
							was_pressed_q <= in_ch.touch_valid;
						end
						state_q <= (pressed && scale_enable_q) ? S_MUL : S_OUT;
					end
				end
				S_MUL:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_OUT : S_MUL;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q  <= sw_a;
			b_q  <= sw_b;
			xr_q <= (sw_a > TOP_X) ? TOP_X : sw_a;
			yr_q <= (sw_b > TOP_Y) ? TOP_Y : sw_b;
		end
		if (state_q == S_MUL) begin
			prod_q    <= PROD_W'(num_abs) * PROD_W'(sel_top);
			den_abs_q <= den_abs;
			zero_q    <= (den == '0) || (num[RAW_W] != den[RAW_W]);
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			if (axis_q) begin
				yr_q <= clamp_res;
			end else begin
				xr_q <= clamp_res;
			end
		end
		if (out_load) begin
			out_pressed_q <= pressed_q;
			out_x_q       <= pressed_q ? mir_x[X_W-1:0] : '0;
			out_y_q       <= pressed_q ? mir_y[Y_W-1:0] : '0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.touch_pressed = out_pressed_q;
	assign out_ch.point_x       = out_x_q;
	assign out_ch.point_y       = out_y_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("input accepted while a transaction was in progress");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result loaded outside the output state");

	a_released_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_pressed_q |-> out_x_q == '0 && out_y_q == '0)
		else $error("released result carries a nonzero point");
`endif

endmodule
